// File: rtl/core/dks_pkg.sv
// Shared constants, tables and permutation functions for the DES key schedule core.
package dks_pkg;

	localparam int KEY_W    = 64;
	localparam int CD_W     = 56;
	localparam int HALF_W   = 28;
	localparam int SUBKEY_W = 48;
	localparam int RND_W    = 5;
	localparam int IDX_W    = 4;
	localparam int ROUNDS_MAX = 16;

	localparam logic [RND_W-1:0] ROUND_COUNT_RST = RND_W'(ROUNDS_MAX);
	localparam logic [IDX_W-1:0] LAST_IDX_MAX    = IDX_W'(ROUNDS_MAX - 1);

	typedef logic [7:0] pos_t;

	localparam pos_t PC1_TAB [CD_W] = '{
		8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,  8'd58, 8'd50, 8'd42, 8'd34,
		8'd26, 8'd18, 8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
		8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,
		8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37,
		8'd29, 8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
	};

	localparam pos_t PC2_TAB [SUBKEY_W] = '{
		8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
		8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
		8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
		8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
	};

	// bit r set: round r+1 rotates by two, else by one
	localparam logic [ROUNDS_MAX-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

	function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] k);
		logic [CD_W-1:0] r;
		r = '0;
		for (int i = 0; i < CD_W; i++) begin
			r[CD_W-1-i] = k[KEY_W - int'(PC1_TAB[i])];
		end
		return r;
	endfunction

	function automatic logic [SUBKEY_W-1:0] pc2(input logic [CD_W-1:0] cd);
		logic [SUBKEY_W-1:0] r;
		r = '0;
		for (int i = 0; i < SUBKEY_W; i++) begin
			r[SUBKEY_W-1-i] = cd[CD_W - int'(PC2_TAB[i])];
		end
		return r;
	endfunction

	function automatic logic [HALF_W-1:0] rotl28(input logic [HALF_W-1:0] x, input logic two);
		logic [HALF_W-1:0] r;
		if (two) begin
			r = {x[HALF_W-3:0], x[HALF_W-1:HALF_W-2]};
		end else begin
			r = {x[HALF_W-2:0], x[HALF_W-1]};
		end
		return r;
	endfunction

endpackage

// File: rtl/core/dks_key_if.sv
// Key input channel interface.
interface dks_key_if;
	logic        valid;
	logic        ready;
	logic [63:0] key;

	modport source (output valid, output key, input ready);
	modport sink   (input valid, input key, output ready);
endinterface

// File: rtl/core/dks_subkey_if.sv
// Subkey output channel interface.
interface dks_subkey_if;
	logic        valid;
	logic        ready;
	logic [47:0] subkey;
	logic [4:0]  round_number;
	logic        last;

	modport source (output valid, output subkey, output round_number, output last, input ready);
	modport sink   (input valid, input subkey, input round_number, input last, output ready);
endinterface

// File: rtl/core/dks_cfg_if.sv
// Configuration write channel interface (round count register).
interface dks_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/des_key_schedule_core.sv
// DES key schedule core: PC1, per-round rotation of C and D, PC2 subkey output.
// A key is taken when idle; the core then emits round_count subkeys (register
// clamped to 1..16), one per cycle while the output side takes them, through
// one rotate per half, shared by all rounds, acting on the C/D registers,
// followed by PC2 into an output register. A key occupies the core from its
// accepting cycle until its last subkey is loaded, output stalls included;
// the next key can be taken the cycle after the last subkey is loaded, even
// while that subkey still waits in the output register.
module des_key_schedule_core (
	input  logic              clk,
	input  logic              arst_n,
	dks_key_if.sink           key,
	dks_subkey_if.source      subkey,
	dks_cfg_if.sink           cfg
);
	import dks_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t              state_q;
	logic [RND_W-1:0]    round_count_q;
	logic [IDX_W-1:0]    round_q;
	logic [IDX_W-1:0]    last_idx_q;
	logic [IDX_W-1:0]    last_idx;
	logic [HALF_W-1:0]   c_q, d_q, c_nxt, d_nxt;
	logic [CD_W-1:0]     cd_init;
	logic                out_valid_q;
	logic [SUBKEY_W-1:0] subkey_q;
	logic [RND_W-1:0]    rnum_q;
	logic                last_q;
	logic                key_acc;
	logic                load;
	logic                load_last;

	assign cfg.ready    = 1'b1;
	assign key.ready    = (state_q == ST_IDLE);
	assign key_acc      = key.valid && key.ready;
	assign load         = (state_q == ST_RUN) && (!out_valid_q || subkey.ready);
	assign load_last    = load && (round_q == last_idx_q);

	assign cd_init = pc1(key.key);
	assign c_nxt   = rotl28(c_q, ROT_TWO[round_q]);
	assign d_nxt   = rotl28(d_q, ROT_TWO[round_q]);

	always_comb begin
		if (round_count_q == '0) begin
			last_idx = '0;
		end else if (round_count_q > ROUND_COUNT_RST) begin
			last_idx = LAST_IDX_MAX;
		end else begin
			last_idx = IDX_W'(round_count_q - RND_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			round_count_q <= ROUND_COUNT_RST;
			round_q       <= '0;
			last_idx_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				round_count_q <= cfg.data;
			end
			case (state_q)
				ST_IDLE: begin
					if (key_acc) begin
						state_q    <= ST_RUN;
						round_q    <= '0;
						last_idx_q <= last_idx;
					end
				end
				ST_RUN: begin
					if (load) begin
						round_q <= round_q + IDX_W'(1);
						if (load_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (subkey.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_acc) begin
			c_q <= cd_init[CD_W-1:HALF_W];
			d_q <= cd_init[HALF_W-1:0];
		end else if (load) begin
			c_q <= c_nxt;
			d_q <= d_nxt;
		end
		if (load) begin
			subkey_q <= pc2({c_nxt, d_nxt});
			rnum_q   <= RND_W'(round_q) + RND_W'(1);
			last_q   <= (round_q == last_idx_q);
		end
	end

	assign subkey.valid        = out_valid_q;
	assign subkey.subkey       = subkey_q;
	assign subkey.round_number = rnum_q;
	assign subkey.last         = last_q;

`ifndef SYNTHESIS
	a_key_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		key_acc |=> (state_q == ST_RUN) && (round_q == '0))
		else $error("key transaction did not start a run");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		load_last |=> (state_q == ST_IDLE) && out_valid_q && last_q)
		else $error("last subkey did not end the run");

	a_rnum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (rnum_q != '0) && (rnum_q <= ROUND_COUNT_RST))
		else $error("round number out of range");

	a_rnum_step: assert property (@(posedge clk) disable iff (!arst_n)
		(load && $past(load) && $past(state_q == ST_RUN) && !$past(load_last))
		|=> (rnum_q == $past(rnum_q) + RND_W'(1)))
		else $error("round number did not advance by one");
`endif

endmodule
